// ===== hw/rtl/idg_pkg.sv =====
package idg_pkg;

    localparam int COUNT_BITS_DFLT = 32;
    localparam int IN_BITS         = 32;
    localparam int DIM_BITS        = 16;
    localparam int TBL_LEN         = 25;
    localparam int IDX_BITS        = $clog2(TBL_LEN);

    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

    localparam logic [DIM_BITS-1:0] TBL_W [TBL_LEN] = '{
        16'd160,  16'd192,  16'd320,  16'd320,  16'd384,
        16'd640,  16'd640,  16'd640,  16'd640,  16'd640,
        16'd720,  16'd720,  16'd768,  16'd1024, 16'd1152,
        16'd1280, 16'd1280, 16'd1440, 16'd1536, 16'd1600,
        16'd1600, 16'd3072, 16'd3200, 16'd3400, 16'd4700
    };

    localparam logic [DIM_BITS-1:0] TBL_H [TBL_LEN] = '{
        16'd120,  16'd128,  16'd200,  16'd240,  16'd256,
        16'd512,  16'd400,  16'd480,  16'd485,  16'd486,
        16'd485,  16'd486,  16'd512,  16'd768,  16'd900,
        16'd960,  16'd1024, 16'd972,  16'd1024, 16'd1200,
        16'd1280, 16'd2048, 16'd4000, 16'd4400, 16'd3300
    };

    // Product of one table pair; only ever called with a constant index.
    function automatic logic [63:0] tbl_product(input int idx);
        return 64'(TBL_W[idx]) * 64'(TBL_H[idx]);
    endfunction

endpackage

// ===== hw/rtl/image_dimension_guesser.sv =====
// Guesses image width and height from a pixel count.
// Input channel: i_valid / o_ready with i_pixel_count, one count per beat.
// Output channel: o_valid / i_ready with o_found, o_width, o_height, one
// result beat for every input beat, in order.
// A count matching a product of the built-in list of common sizes takes the
// first such pair; otherwise a perfect square gives its root as both sides;
// anything else, and a zero count, reports not found with zero dimensions.
// One register for the list compare, one cell per root digit, one output
// register. A new count is taken every cycle while o_ready is high.
// Every stage holds its beat while the one after it is full, so a stalled
// receiver first fills the bubbles and only then drops o_ready; up to
// (COUNT_BITS + 1) / 2 + 2 beats can sit in the block.
// Reset empties all stages; no result is pending after it.
module image_dimension_guesser import idg_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [IN_BITS-1:0]  i_pixel_count,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_found,
    output logic [DIM_BITS-1:0] o_width,
    output logic [DIM_BITS-1:0] o_height
);

    localparam int ROOT_BITS = (COUNT_BITS + 1) / 2;
    localparam int NW        = 2 * ROOT_BITS;
    localparam int REMW      = ROOT_BITS + 2;

    logic                 c_valid [ROOT_BITS+1];
    logic                 c_ready [ROOT_BITS+1];
    logic [NW-1:0]        c_n     [ROOT_BITS+1];
    logic [REMW-1:0]      c_rem   [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] c_root  [ROOT_BITS+1];
    logic                 c_hit   [ROOT_BITS+1];
    logic [IDX_BITS-1:0]  c_idx   [ROOT_BITS+1];
    logic                 c_zero  [ROOT_BITS+1];

    logic                 r_out_valid;
    logic                 r_found;
    logic [DIM_BITS-1:0]  r_width;
    logic [DIM_BITS-1:0]  r_height;

    logic                 n_found;
    logic [DIM_BITS-1:0]  n_width;
    logic [DIM_BITS-1:0]  n_height;
    logic                 out_open;
    logic                 out_take;
    logic                 is_square;

    idg_front #(
        .COUNT_BITS (COUNT_BITS),
        .ROOT_BITS  (ROOT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_count (i_pixel_count),
        .o_valid       (c_valid[0]),
        .i_ready       (c_ready[0]),
        .o_n           (c_n[0]),
        .o_hit         (c_hit[0]),
        .o_idx         (c_idx[0]),
        .o_zero        (c_zero[0])
    );

    // The root starts from an empty remainder and an empty partial root.
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
        idg_root_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_n     (c_n[k]),
            .i_rem   (c_rem[k]),
            .i_root  (c_root[k]),
            .i_hit   (c_hit[k]),
            .i_idx   (c_idx[k]),
            .i_zero  (c_zero[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_n     (c_n[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_root  (c_root[k+1]),
            .o_hit   (c_hit[k+1]),
            .o_idx   (c_idx[k+1]),
            .o_zero  (c_zero[k+1])
        );
    end

    assign out_open            = !r_out_valid || i_ready;
    assign c_ready[ROOT_BITS]  = out_open;
    assign out_take            = c_valid[ROOT_BITS] && out_open;

    // A square counts only if its root fits the dimension fields.
    always_comb begin
        is_square = (c_rem[ROOT_BITS] == '0)
                 && (64'(c_root[ROOT_BITS]) <= 64'(DIM_MAX));
        n_found   = 1'b0;
        n_width   = '0;
        n_height  = '0;
        priority if (c_zero[ROOT_BITS]) begin
            n_found = 1'b0;
        end else if (c_hit[ROOT_BITS]) begin
            n_found  = 1'b1;
            n_width  = TBL_W[c_idx[ROOT_BITS]];
            n_height = TBL_H[c_idx[ROOT_BITS]];
        end else if (is_square) begin
            n_found  = 1'b1;
            n_width  = DIM_BITS'(c_root[ROOT_BITS]);
            n_height = DIM_BITS'(c_root[ROOT_BITS]);
        end else begin
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= c_valid[ROOT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_found  <= n_found;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_found  = r_found;
    assign o_width  = r_width;
    assign o_height = r_height;

`ifndef SYNTHESIS
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_width == '0 && o_height == '0))
        else $error("not-found result carries nonzero dimensions");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_width != '0 && o_height != '0))
        else $error("found result carries a zero dimension");

    a_pairs_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[ROOT_BITS] |-> (c_n[ROOT_BITS] == '0))
        else $error("root chain ended with count bits left over");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result pending right after reset");
`endif

endmodule

// ===== hw/rtl/idg_front.sv =====
module idg_front import idg_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DFLT,
    parameter int ROOT_BITS  = (COUNT_BITS + 1) / 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [IN_BITS-1:0]     i_pixel_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*ROOT_BITS-1:0] o_n,
    output logic                   o_hit,
    output logic [IDX_BITS-1:0]    o_idx,
    output logic                   o_zero
);

    localparam int NW = 2 * ROOT_BITS;

    logic                r_valid;
    logic [NW-1:0]       r_n;
    logic                r_hit;
    logic [IDX_BITS-1:0] r_idx;
    logic                r_zero;

    logic [NW-1:0]       n_n;
    logic                n_hit;
    logic [IDX_BITS-1:0] n_idx;
    logic                n_zero;
    logic [63:0]         pc_ext;
    logic [63:0]         cnt_ext;
    logic                take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // Bits of the count at and above COUNT_BITS are dropped here.
    always_comb begin
        pc_ext  = 64'(i_pixel_count);
        cnt_ext = 64'(pc_ext[COUNT_BITS-1:0]);
        n_n     = NW'(cnt_ext);
        n_zero  = (cnt_ext == 64'd0);
        n_hit   = 1'b0;
        n_idx   = '0;
        // Walk from the back so the earliest matching pair wins.
        for (int i = TBL_LEN - 1; i >= 0; i--) begin
            if (cnt_ext == tbl_product(i)) begin
                n_hit = 1'b1;
                n_idx = IDX_BITS'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_n    <= n_n;
            r_hit  <= n_hit;
            r_idx  <= n_idx;
            r_zero <= n_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_hit   = r_hit;
    assign o_idx   = r_idx;
    assign o_zero  = r_zero;

endmodule

// ===== hw/rtl/idg_root_cell.sv =====
module idg_root_cell import idg_pkg::*; #(
    parameter int ROOT_BITS = (COUNT_BITS_DFLT + 1) / 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2*ROOT_BITS-1:0] i_n,
    input  logic [ROOT_BITS+1:0]   i_rem,
    input  logic [ROOT_BITS-1:0]   i_root,
    input  logic                   i_hit,
    input  logic [IDX_BITS-1:0]    i_idx,
    input  logic                   i_zero,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*ROOT_BITS-1:0] o_n,
    output logic [ROOT_BITS+1:0]   o_rem,
    output logic [ROOT_BITS-1:0]   o_root,
    output logic                   o_hit,
    output logic [IDX_BITS-1:0]    o_idx,
    output logic                   o_zero
);

    localparam int NW   = 2 * ROOT_BITS;
    localparam int REMW = ROOT_BITS + 2;

    logic                 r_valid;
    logic [NW-1:0]        r_n;
    logic [REMW-1:0]      r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic                 r_hit;
    logic [IDX_BITS-1:0]  r_idx;
    logic                 r_zero;

    logic [NW-1:0]        n_n;
    logic [REMW-1:0]      n_rem;
    logic [ROOT_BITS-1:0] n_root;
    logic [REMW-1:0]      rem_sh;
    logic [REMW-1:0]      trial;
    logic                 fits;
    logic                 take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // One digit of the root: bring down the next bit pair and try 4r+1.
    // The remainder never exceeds twice the partial root, so its top two
    // bits are always clear before the shift.
    always_comb begin
        rem_sh = {i_rem[REMW-3:0], i_n[NW-1 -: 2]};
        trial  = {i_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[ROOT_BITS-2:0], fits};
        n_n    = {i_n[NW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_n    <= n_n;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_hit  <= i_hit;
            r_idx  <= i_idx;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_hit   = r_hit;
    assign o_idx   = r_idx;
    assign o_zero  = r_zero;

endmodule
